/* rtl/sha256_pkg.sv */
// shared types and constants for the sha-256 engine
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       absorb;      // write byte, bump count
    logic       pad_mark;    // write 0x80 at fill, clear the rest
    logic       clear_blk;   // zero the words below the length words
    logic       put_len;     // write length words
    logic       comp_start;  // load working vars and schedule
    logic       comp_round;  // one round
    logic       comp_final;  // fold into hash words
    logic       reinit;      // restore initial hash and clear count
    logic [5:0] round;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] pos;  // current byte fill
  } dp_sts_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/sha256_datapath.sv */
// sha-256 datapath: block buffer, schedule, round logic, hash words, bit count
`timescale 1ns / 1ps
module sha256_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           byte_i,
  input  sha256_pkg::dp_cmd_t  cmd_i,
  output sha256_pkg::dp_sts_t  sts_o,
  output logic [31:0]          hash_word_o
);
  import sha256_pkg::*;

  logic [31:0] blk_q [16];
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [63:0] cnt_q;

  logic [5:0]  pos;
  logic [3:0]  wsel;
  logic [4:0]  shamt;
  logic [31:0] wt, sm0, sm1, s0, s1, chs, mj, t_one, t_two, sched_new;

  assign pos   = cnt_q[8:3];
  assign wsel  = pos[5:2];
  assign shamt = {~pos[1:0], 3'b000};
  assign sts_o.pos = pos;
  assign hash_word_o = h_q[cmd_i.out_idx];

  // schedule kept as a 16-word shift line, w_q[0] is the current word
  always_comb begin
    sm1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    sm0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sched_new = sm1 + w_q[9] + sm0 + w_q[0];
    wt   = w_q[0];
    s1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    chs  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t_one = v_q[7] + s1 + chs + RoundConst[cmd_i.round] + wt;
    s0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t_two = s0 + mj;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      if (pos[1:0] == 2'd0) blk_q[wsel] <= {byte_i, 24'd0};
      else blk_q[wsel] <= blk_q[wsel] | (32'(byte_i) << shamt);
    end
    if (cmd_i.pad_mark) begin
      for (int i = 0; i < 16; i++) begin
        // length words are left to put_len
        if (4'(i) > wsel && !(cmd_i.put_len && i >= 14)) blk_q[i] <= '0;
      end
      if (pos[1:0] == 2'd0) blk_q[wsel] <= 32'h8000_0000;
      else blk_q[wsel] <= blk_q[wsel] | (32'h80 << shamt);
    end
    if (cmd_i.clear_blk) begin
      for (int i = 0; i < 14; i++) blk_q[i] <= '0;
    end
    if (cmd_i.put_len) begin
      blk_q[14] <= cnt_q[63:32];
      blk_q[15] <= cnt_q[31:0];
    end
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_q[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end
    if (cmd_i.comp_round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= sched_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t_one;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t_one + t_two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      cnt_q <= '0;
    end else begin
      if (cmd_i.absorb) cnt_q <= cnt_q + 64'd8;
      if (cmd_i.comp_final) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
        cnt_q <= '0;
      end
    end
  end

endmodule

/* rtl/sha256_ctrl.sv */
// sha-256 controller: sequences absorb, padding, compression and digest output
`timescale 1ns / 1ps
module sha256_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            out_idx_o,
  output sha256_pkg::dp_cmd_t   cmd_o,
  input  sha256_pkg::dp_sts_t   sts_i
);
  import sha256_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StStart = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StFold  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam logic [2:0] StLen   = 3'd6;

  logic [2:0] st_q, st_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       fin_q, fin_d;   // padding or length block pending after this compression
  logic       len_q, len_d;   // compression in flight is the length block
  logic       acc;

  assign in_stall_o  = (st_q != StIdle);
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = (st_q == StOut);
  assign out_idx_o   = idx_q;

  always_comb begin
    st_d = st_q; rnd_d = rnd_q; idx_d = idx_q; fin_d = fin_q; len_d = len_q;
    cmd_o = '0;
    cmd_o.round = rnd_q;
    cmd_o.out_idx = idx_q;
    case (st_q)
      StIdle: begin
        if (acc) begin
          cmd_o.absorb = in_data_i.has_byte;
          fin_d = in_data_i.end_of_message;
          len_d = 1'b0;
          if (in_data_i.has_byte && sts_i.pos == 6'd63) st_d = StStart;
          else if (in_data_i.end_of_message) st_d = StPad;
        end
      end
      StPad: begin
        cmd_o.pad_mark = 1'b1;
        st_d = StStart;
        if (sts_i.pos >= 6'd56) begin
          fin_d = 1'b1;  // length goes into a fresh block
        end else begin
          cmd_o.put_len = 1'b1;
          fin_d = 1'b0;
          len_d = 1'b1;
        end
      end
      StLen: begin
        cmd_o.clear_blk = 1'b1;
        cmd_o.put_len = 1'b1;
        fin_d = 1'b0;
        len_d = 1'b1;
        st_d = StStart;
      end
      StStart: begin
        cmd_o.comp_start = 1'b1;
        rnd_d = '0;
        st_d = StRound;
      end
      StRound: begin
        cmd_o.comp_round = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) st_d = StFold;
      end
      StFold: begin
        cmd_o.comp_final = 1'b1;
        if (len_q) begin
          st_d = StOut;
          idx_d = '0;
        end else if (fin_q) begin
          // spilled padding needs the length block, a full block still needs padding
          if (sts_i.pos >= 6'd56) st_d = StLen;
          else st_d = StPad;
        end else begin
          st_d = StIdle;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            st_d = StIdle;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rnd_q <= '0; idx_q <= '0; fin_q <= 1'b0; len_q <= 1'b0;
    end else begin
      st_q <= st_d; rnd_q <= rnd_d; idx_q <= idx_d; fin_q <= fin_d; len_q <= len_d;
    end
  end

endmodule

/* rtl/sha256_hash_engine_unit.sv */
// sha-256 engine top level: controller, datapath and output register
`timescale 1ns / 1ps
// one request per cycle while a block fills; the request completing a block stalls
// input through its compression (load, 64 rounds of the single round unit, fold)
// end of message adds a padding step and a compression; a spilled length
// adds a setup step and a second compression, then eight digest words
// reset: async active low, hash words to the initial values, bit count to zero
module sha256_hash_engine_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_item_t out_data_o
);
  import sha256_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  idx;
  logic [31:0] hword;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_idx_o(idx), .cmd_o(cmd), .sts_i(sts)
  );

  sha256_datapath u_dp (
    .clk_i, .rst_ni, .byte_i(in_data_i.msg_byte), .cmd_i(cmd), .sts_o(sts),
    .hash_word_o(hword)
  );

  assign out_data_o.digest_word = hword;
  assign out_data_o.word_index  = idx;
  assign out_data_o.last_word   = (idx == 3'd7);

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during digest output");
  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && idx != 3'd7) |=> (out_valid_o && idx == $past(idx) + 3'd1))
    else $error("digest index skipped");
  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && idx == 3'd7) |=> !out_valid_o)
    else $error("output continued past last word");

endmodule

/* tb/tb.sv */
// self-checking testbench for the sha-256 hash engine
`timescale 1ns / 1ps
module tb;
  import sha256_pkg::*;

  localparam int StallLimit = 1000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  sha256_hash_engine_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // predictor state
  logic [31:0] hash_st [8];
  logic [31:0] blk_st [16];
  logic [63:0] bit_cnt;
  out_item_t   digest_q [$];
  int          fail_cnt;
  int          digest_cnt;
  int          msg_cnt;
  int          idle_cycles = 0;
  bit          quiet_out;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, w2, w15, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_st[i];
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        w2 = w[(t - 2) & 15];
        w15 = w[(t - 15) & 15];
        wt = (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10)) + w[(t - 7) & 15]
           + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w[t & 15];
        w[t & 15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    if ((pos & 3) == 0) blk_st[pos >> 2] = {b, 24'h0};
    else blk_st[pos >> 2] |= 32'(b) << ((3 - (pos & 3)) * 8);
  endtask

  task automatic reset_hash();
    for (int i = 0; i < 8; i++) hash_st[i] = InitHash[i];
    bit_cnt = '0;
  endtask

  task automatic predict_digest(in_item_t it);
    int pos;
    out_item_t r;
    if (it.has_byte) begin
      pos = int'(bit_cnt[8:3]);
      place_byte(pos, it.msg_byte);
      bit_cnt += 64'd8;
      if (pos == 63) compress();
    end
    if (!it.end_of_message) return;
    pos = int'(bit_cnt[8:3]);
    place_byte(pos, 8'h80);
    for (int i = (pos >> 2) + 1; i < 16; i++) blk_st[i] = '0;
    if (pos >= 56) begin
      compress();
      for (int i = 0; i < 16; i++) blk_st[i] = '0;
    end
    blk_st[14] = bit_cnt[63:32];
    blk_st[15] = bit_cnt[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      r.digest_word = hash_st[i];
      r.word_index = 3'(i);
      r.last_word = (i == 7);
      digest_q = {digest_q, r};
    end
    reset_hash();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: random stall, compare at the rising edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("digest word with no expectation: %h", out_data_o.digest_word);
          fail_cnt++;
        end else begin
          out_item_t e;
          e = digest_q.pop_front();
          if (out_data_o.digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, out_data_o.digest_word);
            fail_cnt++;
          end
          if (out_data_o.word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, out_data_o.word_index);
            fail_cnt++;
          end
          if (out_data_o.last_word !== e.last_word) begin
            $error("last_word expected %0d actual %0d", e.last_word, out_data_o.last_word);
            fail_cnt++;
          end
          digest_cnt++;
        end
      end
      @(negedge clk_i);
      out_stall_i <= quiet_out ? 1'b0 : ($urandom_range(99) < 20);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  bit quiet_in;

  // valid stays high after the request; the next request or the caller drops it
  task automatic send_req(in_item_t it);
    while (!quiet_in && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_data_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_digest(it);
    if (it.end_of_message) msg_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_msg(int len, bit last_empty, logic [7:0] fill, bit rnd);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.msg_byte = rnd ? 8'($urandom) : fill;
      it.has_byte = 1'b1;
      it.end_of_message = (i == len - 1) && !last_empty;
      send_req(it);
      if ($urandom_range(31) == 0) begin
        // ignored item in the middle
        it = '{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b0};
        send_req(it);
      end
    end
    if (last_empty || len == 0) begin
      it = '{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b1};
      send_req(it);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (digest_q.size() != 0) @(negedge clk_i);
  endtask

  // directed table: byte, has, end, and digest word 0 where it is known
  typedef struct {
    in_item_t    it;
    bit          known;
    logic [31:0] word0;
  } dir_row_t;
  dir_row_t dir_tab [] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, 32'he3b0c442},  // empty message
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, 32'h0},        // no byte, no end
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, 32'hba7816bf},  // "abc", byte with end
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, 32'h0},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, 32'h0},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h63, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, 32'hba7816bf}   // "abc" then empty end
  };

  initial begin
    int n_msgs;
    fail_cnt = 0; digest_cnt = 0; msg_cnt = 0;
    quiet_in = 1'b0; quiet_out = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0;
    for (int i = 0; i < 16; i++) blk_st[i] = '0;
    reset_hash();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[k]) begin
      send_req(dir_tab[k].it);
      // the last eight expectations belong to this message
      if (dir_tab[k].known &&
          digest_q[digest_q.size() - 8].digest_word !== dir_tab[k].word0) begin
        $error("digest_word expected %h actual %h (predictor)", dir_tab[k].word0,
               digest_q[digest_q.size() - 8].digest_word);
        fail_cnt++;
      end
    end
    // length spills into a second block
    send_msg(56, 1'b0, 8'hff, 1'b0);

    // sender holds off until all digests are back
    drain();

    // stretch with no idling on either side: full block with end on the last byte
    quiet_in = 1'b1; quiet_out = 1'b1;
    send_msg(64, 1'b0, 8'h00, 1'b1);
    quiet_in = 1'b0; quiet_out = 1'b0;

    // a few short random messages
    n_msgs = 0;
    while (n_msgs < 3) begin
      send_msg($urandom_range(5), $urandom_range(3) == 0, 8'h00, 1'b1);
      n_msgs++;
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("covered %0d messages, %0d digest words checked", msg_cnt, digest_cnt);
    $display("padding spill, full block at end, empty and ignored items, random stalls");
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
